@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("forbidden condition seen");

`endif

@@ src/hcb_pkg.sv @@
// ----------------------------------------------------------------------------
// Huffman code table builder package
// Shared widths, parameter defaults and the sequencer state type.
// ----------------------------------------------------------------------------
package hcb_pkg;

  localparam int unsigned DEF_SYMBOLS    = 40;
  localparam int unsigned DEF_COUNT_BITS = 24;
  localparam int unsigned SYM_W          = 6;
  localparam int unsigned FREQ_IN_W      = 24;
  localparam int unsigned CODE_W         = 40;
  localparam int unsigned LEN_W          = 6;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SCAN,
    S_LEAF,
    S_SU,
    S_SD_LD,
    S_SD_LDF,
    S_SD_LDC,
    S_SD_RD,
    S_SD_RDF,
    S_SD_CMP,
    S_MG_CHK,
    S_POP_RD,
    S_POP_WR,
    S_POP_DONE,
    S_MG_RD,
    S_MG_WR,
    S_TREE,
    S_TW_CHK,
    S_TW_L,
    S_TW_R,
    S_EMPTY,
    S_EM_SCAN,
    S_EM_LD,
    S_EM_WAIT,
    S_FINISH
  } hcb_state_e;

endpackage

@@ src/hcb_if.sv @@
// ----------------------------------------------------------------------------
// Huffman code table builder channels
// Count input channel and code result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface hcb_in_if import hcb_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [SYM_W-1:0]     symbol;
  logic [FREQ_IN_W-1:0] frequency;
  logic                 last;

  modport source (output valid, output symbol, output frequency, output last,
                  input ready);
  modport sink (input valid, input symbol, input frequency, input last,
                output ready);
endinterface

interface hcb_out_if import hcb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SYM_W-1:0]  out_symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;
  logic              none_present;
  logic              last_code;

  modport source (output valid, output out_symbol, output code_bits,
                  output code_length, output none_present, output last_code,
                  input ready);
  modport sink (input valid, input out_symbol, input code_bits,
                input code_length, input none_present, input last_code,
                output ready);
endinterface

@@ src/huffman_code_table_builder.sv @@
// ----------------------------------------------------------------------------
// Huffman code table builder
// Collects symbol counts and builds a Huffman code table with a min-heap.
// ----------------------------------------------------------------------------
// Usage: counts arrive on in_i, one transfer per cycle while the block is
// idle. Each transfer stores the count of one symbol; a zero count marks the
// symbol absent and an index beyond the alphabet is ignored. A transfer with
// last set starts the build, and in_i.ready stays low until all results of
// that build have been taken. The build inserts present symbols into a heap,
// merges the two smallest nodes until one remains, walks the tree from the
// root and then sends one result per present symbol in index order on out_o.
// Every heap level steps through S_SD_RD, S_SD_RDF and S_SD_CMP of the shared
// compare unit; each result then steps through S_EM_SCAN, S_EM_LD and
// S_EM_WAIT, which waits out any stall, and each absent symbol is skipped in
// S_EM_SCAN. An empty alphabet gives one flagged result.
// Results sit in an output register; when the receiver stalls the sequencer
// waits. Reset marks every symbol absent and returns the block to idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module huffman_code_table_builder import hcb_pkg::*; #(
  parameter int unsigned SYMBOLS    = DEF_SYMBOLS,
  parameter int unsigned COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  hcb_in_if.sink    in_i,
  hcb_out_if.source out_o
);

  localparam int unsigned NODES  = 2 * SYMBOLS - 1;
  localparam int unsigned NID_W  = $clog2(NODES);
  localparam int unsigned SLOT_W = $clog2(SYMBOLS);
  localparam int unsigned SIZE_W = $clog2(SYMBOLS + 1);
  localparam int unsigned HIX_W  = $clog2(2 * SYMBOLS + 1);
  localparam int unsigned FREQ_W = COUNT_BITS + $clog2(SYMBOLS);
  localparam int unsigned CM_W   = CODE_W + LEN_W;

  hcb_state_e state_q, state_d;

  logic [SYMBOLS-1:0] present_q, present_d;
  logic [SIZE_W-1:0]  size_q, size_d;
  logic [SIZE_W-1:0]  s_q, s_d;
  logic [NID_W-1:0]   n_q, n_d;
  logic [NID_W-1:0]   nxt_q, nxt_d;
  logic [NID_W-1:0]   k_q, k_d;
  logic [NID_W-1:0]   tw_id_q, tw_id_d;
  logic [SLOT_W-1:0]  sd_i_q, sd_i_d;
  logic [SLOT_W-1:0]  ui_q, ui_d;
  logic [NID_W-1:0]   cur_id_q, cur_id_d;
  logic [FREQ_W-1:0]  cur_f_q, cur_f_d;
  logic [NID_W-1:0]   pl_q, pl_d;
  logic [NID_W-1:0]   pr_q, pr_d;
  logic               sd_to_pop_q, sd_to_pop_d;
  logic               merging_q, merging_d;
  logic               second_q, second_d;
  logic               out_valid_q, out_valid_d;

  logic [SYM_W-1:0]   o_sym_q, o_sym_d;
  logic [CODE_W-1:0]  o_bits_q, o_bits_d;
  logic [LEN_W-1:0]   o_len_q, o_len_d;
  logic               o_none_q, o_none_d;
  logic               o_last_q, o_last_d;

  logic [COUNT_BITS-1:0] cnt_mem [SYMBOLS];
  logic [COUNT_BITS-1:0] cnt_rd_q;
  logic                  cnt_we, cnt_re;
  logic [COUNT_BITS-1:0] cnt_wd;

  logic [FREQ_W-1:0] freq_mem [NODES];
  logic [FREQ_W-1:0] freq_rda_q, freq_rdb_q;
  logic              freq_we, freq_re;
  logic [NID_W-1:0]  freq_wa, freq_raa, freq_rab;
  logic [FREQ_W-1:0] freq_wd;

  logic [NID_W-1:0]  slot_mem [SYMBOLS];
  logic [NID_W-1:0]  slot_rda_q, slot_rdb_q;
  logic              slot_we, slot_re;
  logic [SLOT_W-1:0] slot_wa, slot_raa, slot_rab;
  logic [NID_W-1:0]  slot_wd;

  logic [2*NID_W-1:0] ch_mem [NODES];
  logic [2*NID_W-1:0] ch_rd_q;
  logic               ch_we, ch_re;

  logic [CM_W-1:0]  code_mem [NODES];
  logic [CM_W-1:0]  code_rd_q;
  logic             code_we, code_re;
  logic [NID_W-1:0] code_wa, code_ra;
  logic [CM_W-1:0]  code_wd;

  logic              in_xfer, out_xfer, sym_ok, cur_present;
  logic [HIX_W-1:0]  sd_l, sd_r;
  logic              l_in, r_in, lt_l, lt_r;
  logic [FREQ_W-1:0] sel_f;
  logic [NID_W-1:0]  tw_l, tw_r;
  logic              tw_ok;
  logic [LEN_W-1:0]  kid_len;
  logic [CODE_W-1:0] kid_bits;

  assign in_xfer     = in_i.valid && in_i.ready;
  assign out_xfer    = out_valid_q && out_o.ready;
  assign sym_ok      = (7'(in_i.symbol) < 7'(SYMBOLS));
  assign cur_present = (s_q != SIZE_W'(SYMBOLS)) && present_q[s_q[SLOT_W-1:0]];

  assign sd_l  = HIX_W'({sd_i_q, 1'b1});
  assign sd_r  = sd_l + HIX_W'(1);
  assign l_in  = sd_l < HIX_W'(size_q);
  assign r_in  = sd_r < HIX_W'(size_q);
  assign lt_l  = freq_rda_q < cur_f_q;
  assign sel_f = lt_l ? freq_rda_q : cur_f_q;
  assign lt_r  = r_in && (freq_rdb_q < sel_f);

  assign tw_l     = ch_rd_q[2*NID_W-1:NID_W];
  assign tw_r     = ch_rd_q[NID_W-1:0];
  assign tw_ok    = (tw_l < tw_id_q) && (tw_r < tw_id_q);
  assign kid_len  = code_rd_q[CM_W-1:CODE_W] + LEN_W'(1);
  assign kid_bits = {code_rd_q[CODE_W-2:0], 1'b0};

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer && in_i.last) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (s_q == SIZE_W'(SYMBOLS)) begin
          state_d = (n_q == '0) ? S_EMPTY : S_MG_CHK;
        end else if (cur_present) begin
          state_d = S_LEAF;
        end
      end
      S_LEAF:     state_d = S_SU;
      S_SU: begin
        if (ui_q == '0) begin
          state_d = merging_q ? S_MG_CHK : S_SCAN;
        end else begin
          state_d = S_SD_LD;
        end
      end
      S_SD_LD:    state_d = S_SD_LDF;
      S_SD_LDF:   state_d = S_SD_LDC;
      S_SD_LDC:   state_d = S_SD_RD;
      S_SD_RD: begin
        if (!l_in) begin
          state_d = sd_to_pop_q ? S_POP_DONE : S_SU;
        end else begin
          state_d = S_SD_RDF;
        end
      end
      S_SD_RDF:   state_d = S_SD_CMP;
      S_SD_CMP: begin
        if (lt_r || lt_l) begin
          state_d = S_SD_RD;
        end else begin
          state_d = sd_to_pop_q ? S_POP_DONE : S_SU;
        end
      end
      S_MG_CHK:   state_d = (size_q > SIZE_W'(1)) ? S_POP_RD : S_TREE;
      S_POP_RD:   state_d = S_POP_WR;
      S_POP_WR:   state_d = S_SD_LD;
      S_POP_DONE: state_d = second_q ? S_MG_RD : S_POP_RD;
      S_MG_RD:    state_d = S_MG_WR;
      S_MG_WR:    state_d = S_SU;
      S_TREE:     state_d = S_TW_CHK;
      S_TW_CHK:   state_d = (tw_id_q < n_q) ? S_EM_SCAN : S_TW_L;
      S_TW_L:     state_d = tw_ok ? S_TW_R : S_TW_CHK;
      S_TW_R:     state_d = S_TW_CHK;
      S_EMPTY:    state_d = S_EM_WAIT;
      S_EM_SCAN: begin
        if (s_q == SIZE_W'(SYMBOLS)) begin
          state_d = S_FINISH;
        end else if (cur_present) begin
          state_d = S_EM_LD;
        end
      end
      S_EM_LD:    state_d = S_EM_WAIT;
      S_EM_WAIT: begin
        if (out_xfer) begin
          state_d = S_EM_SCAN;
        end
      end
      S_FINISH:   state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  always_comb begin
    present_d   = present_q;
    size_d      = size_q;
    s_d         = s_q;
    n_d         = n_q;
    nxt_d       = nxt_q;
    k_d         = k_q;
    tw_id_d     = tw_id_q;
    sd_i_d      = sd_i_q;
    ui_d        = ui_q;
    cur_id_d    = cur_id_q;
    cur_f_d     = cur_f_q;
    pl_d        = pl_q;
    pr_d        = pr_q;
    sd_to_pop_d = sd_to_pop_q;
    merging_d   = merging_q;
    second_d    = second_q;
    out_valid_d = out_valid_q;
    o_sym_d     = o_sym_q;
    o_bits_d    = o_bits_q;
    o_len_d     = o_len_q;
    o_none_d    = o_none_q;
    o_last_d    = o_last_q;

    in_i.ready = (state_q == S_IDLE);

    cnt_we   = 1'b0;
    cnt_re   = 1'b0;
    cnt_wd   = COUNT_BITS'(in_i.frequency);
    freq_we  = 1'b0;
    freq_re  = 1'b0;
    freq_wa  = n_q;
    freq_raa = slot_rda_q;
    freq_rab = slot_rdb_q;
    freq_wd  = FREQ_W'(cnt_rd_q);
    slot_we  = 1'b0;
    slot_re  = 1'b0;
    slot_wa  = sd_i_q;
    slot_wd  = cur_id_q;
    slot_raa = sd_l[SLOT_W-1:0];
    slot_rab = sd_r[SLOT_W-1:0];
    ch_we    = 1'b0;
    ch_re    = 1'b0;
    code_we  = 1'b0;
    code_re  = 1'b0;
    code_wa  = tw_l;
    code_ra  = tw_id_q;
    code_wd  = {kid_len, kid_bits};

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          if (sym_ok) begin
            cnt_we = 1'b1;
            present_d[in_i.symbol[SLOT_W-1:0]] = (cnt_wd != '0);
          end
          if (in_i.last) begin
            s_d       = '0;
            n_d       = '0;
            size_d    = '0;
            merging_d = 1'b0;
            second_d  = 1'b0;
          end
        end
      end
      S_SCAN: begin
        if (s_q == SIZE_W'(SYMBOLS)) begin
          nxt_d     = n_q;
          merging_d = 1'b1;
          s_d       = '0;
        end else if (cur_present) begin
          cnt_re = 1'b1;
        end else begin
          s_d = s_q + SIZE_W'(1);
        end
      end
      S_LEAF: begin
        freq_we     = 1'b1;
        slot_we     = 1'b1;
        slot_wa     = SLOT_W'(size_q);
        slot_wd     = n_q;
        size_d      = size_q + SIZE_W'(1);
        ui_d        = SLOT_W'(size_q);
        n_d         = n_q + NID_W'(1);
        s_d         = s_q + SIZE_W'(1);
        sd_to_pop_d = 1'b0;
      end
      S_SU: begin
        if (ui_q != '0) begin
          sd_i_d = (ui_q - SLOT_W'(1)) >> 1;
          ui_d   = (ui_q - SLOT_W'(1)) >> 1;
        end
      end
      S_SD_LD: begin
        slot_re  = 1'b1;
        slot_raa = sd_i_q;
      end
      S_SD_LDF: begin
        cur_id_d = slot_rda_q;
        freq_re  = 1'b1;
      end
      S_SD_LDC: begin
        cur_f_d = freq_rda_q;
      end
      S_SD_RD: begin
        if (!l_in) begin
          slot_we = 1'b1;
        end else begin
          slot_re = 1'b1;
        end
      end
      S_SD_RDF: begin
        freq_re = 1'b1;
      end
      S_SD_CMP: begin
        slot_we = 1'b1;
        if (lt_r) begin
          slot_wd = slot_rdb_q;
          sd_i_d  = sd_r[SLOT_W-1:0];
        end else if (lt_l) begin
          slot_wd = slot_rda_q;
          sd_i_d  = sd_l[SLOT_W-1:0];
        end
      end
      S_POP_RD: begin
        slot_re  = 1'b1;
        slot_raa = '0;
        slot_rab = SLOT_W'(size_q - SIZE_W'(1));
      end
      S_POP_WR: begin
        if (second_q) begin
          pr_d = slot_rda_q;
        end else begin
          pl_d = slot_rda_q;
        end
        slot_we     = 1'b1;
        slot_wa     = '0;
        slot_wd     = slot_rdb_q;
        size_d      = size_q - SIZE_W'(1);
        sd_i_d      = '0;
        sd_to_pop_d = 1'b1;
      end
      S_POP_DONE: begin
        second_d = !second_q;
      end
      S_MG_RD: begin
        freq_re  = 1'b1;
        freq_raa = pl_q;
        freq_rab = pr_q;
      end
      S_MG_WR: begin
        freq_we     = 1'b1;
        freq_wa     = nxt_q;
        freq_wd     = freq_rda_q + freq_rdb_q;
        ch_we       = 1'b1;
        slot_we     = 1'b1;
        slot_wa     = SLOT_W'(size_q);
        slot_wd     = nxt_q;
        size_d      = size_q + SIZE_W'(1);
        ui_d        = SLOT_W'(size_q);
        nxt_d       = nxt_q + NID_W'(1);
        sd_to_pop_d = 1'b0;
      end
      S_TREE: begin
        code_we = 1'b1;
        code_wa = nxt_q - NID_W'(1);
        code_wd = '0;
        tw_id_d = nxt_q - NID_W'(1);
      end
      S_TW_CHK: begin
        if (tw_id_q < n_q) begin
          s_d = '0;
          k_d = '0;
        end else begin
          ch_re   = 1'b1;
          code_re = 1'b1;
        end
      end
      S_TW_L: begin
        if (tw_ok) begin
          code_we = 1'b1;
        end else begin
          tw_id_d = tw_id_q - NID_W'(1);
        end
      end
      S_TW_R: begin
        code_we = 1'b1;
        code_wa = tw_r;
        code_wd = {kid_len, kid_bits | CODE_W'(1)};
        tw_id_d = tw_id_q - NID_W'(1);
      end
      S_EMPTY: begin
        o_sym_d     = '0;
        o_bits_d    = '0;
        o_len_d     = '0;
        o_none_d    = 1'b1;
        o_last_d    = 1'b1;
        out_valid_d = 1'b1;
        s_d         = '0;
        k_d         = '0;
      end
      S_EM_SCAN: begin
        if (cur_present) begin
          code_re = 1'b1;
          code_ra = k_q;
        end else if (s_q != SIZE_W'(SYMBOLS)) begin
          s_d = s_q + SIZE_W'(1);
        end
      end
      S_EM_LD: begin
        o_sym_d     = SYM_W'(s_q);
        o_bits_d    = code_rd_q[CODE_W-1:0];
        o_len_d     = code_rd_q[CM_W-1:CODE_W];
        o_none_d    = 1'b0;
        o_last_d    = (k_q == n_q - NID_W'(1));
        out_valid_d = 1'b1;
      end
      S_EM_WAIT: begin
        if (out_xfer) begin
          out_valid_d = 1'b0;
          s_d         = s_q + SIZE_W'(1);
          k_d         = k_q + NID_W'(1);
        end
      end
      S_FINISH: begin
        present_d = '0;
        size_d    = '0;
        n_d       = '0;
      end
      default: begin
        present_d = present_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[in_i.symbol[SLOT_W-1:0]] <= cnt_wd;
    end
    if (cnt_re) begin
      cnt_rd_q <= cnt_mem[s_q[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (freq_we) begin
      freq_mem[freq_wa] <= freq_wd;
    end
    if (freq_re) begin
      freq_rda_q <= freq_mem[freq_raa];
      freq_rdb_q <= freq_mem[freq_rab];
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_wa] <= slot_wd;
    end
    if (slot_re) begin
      slot_rda_q <= slot_mem[slot_raa];
      slot_rdb_q <= slot_mem[slot_rab];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ch_we) begin
      ch_mem[nxt_q] <= {pl_q, pr_q};
    end
    if (ch_re) begin
      ch_rd_q <= ch_mem[tw_id_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (code_we) begin
      code_mem[code_wa] <= code_wd;
    end
    if (code_re) begin
      code_rd_q <= code_mem[code_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      present_q   <= '0;
      size_q      <= '0;
      s_q         <= '0;
      n_q         <= '0;
      nxt_q       <= '0;
      k_q         <= '0;
      tw_id_q     <= '0;
      sd_i_q      <= '0;
      ui_q        <= '0;
      sd_to_pop_q <= 1'b0;
      merging_q   <= 1'b0;
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      present_q   <= present_d;
      size_q      <= size_d;
      s_q         <= s_d;
      n_q         <= n_d;
      nxt_q       <= nxt_d;
      k_q         <= k_d;
      tw_id_q     <= tw_id_d;
      sd_i_q      <= sd_i_d;
      ui_q        <= ui_d;
      sd_to_pop_q <= sd_to_pop_d;
      merging_q   <= merging_d;
      second_q    <= second_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_id_q <= cur_id_d;
    cur_f_q  <= cur_f_d;
    pl_q     <= pl_d;
    pr_q     <= pr_d;
    o_sym_q  <= o_sym_d;
    o_bits_q <= o_bits_d;
    o_len_q  <= o_len_d;
    o_none_q <= o_none_d;
    o_last_q <= o_last_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_symbol   = o_sym_q;
  assign out_o.code_bits    = o_bits_q;
  assign out_o.code_length  = o_len_q;
  assign out_o.none_present = o_none_q;
  assign out_o.last_code    = o_last_q;

  `ASSERT_NEVER(a_ready_while_result, in_i.ready && out_valid_q)
  `ASSERT_HOLDS(a_heap_bound, size_q <= SIZE_W'(SYMBOLS))
  `ASSERT_HOLDS(a_leaf_bound, n_q <= NID_W'(SYMBOLS))

endmodule

@@ verif/huffman_code_table_builder_tb_if.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Huffman code table builder test types
// Test-side record type for code results, kept by the testbench scoreboard.
// ----------------------------------------------------------------------------
// The block's own interfaces in the source tree are used directly; this file
// only holds the small record type that the scoreboard keeps.
package hcb_tb_pkg;
  import hcb_pkg::*;

  typedef struct packed {
    logic [SYM_W-1:0]  out_symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
    logic              none_present;
    logic              last_code;
  } code_entry_t;
endpackage

@@ verif/huffman_code_table_builder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Huffman code table builder testbench
// Drives count sets with random gaps and stalls, predicts every code table
// with a software heap and tree, and compares each result transfer in order.
// ----------------------------------------------------------------------------
module huffman_code_table_builder_tb;
  import hcb_pkg::*;
  import hcb_tb_pkg::*;

  localparam int NSYM  = DEF_SYMBOLS;
  localparam int NNODE = 2 * NSYM - 1;
  localparam int NOKID = 127;

  class code_table_scoreboard;
    logic [23:0] counts [NSYM];
    longint unsigned nfreq [NNODE];
    int kid_l [NNODE];
    int kid_r [NNODE];
    int nsym [NNODE];
    int slots [NSYM];
    int hsize;
    logic [CODE_W-1:0] ncode [NNODE];
    int nlen [NNODE];
    code_entry_t pending [$];
    int errors;
    int builds;
    int codes_seen;

    function void clear_counts();
      foreach (counts[i]) counts[i] = '0;
    endfunction

    function void sift_down(int size, int i);
      int sm;
      int t;
      forever begin
        sm = i;
        if (2*i+1 < size && nfreq[slots[2*i+1]] < nfreq[slots[sm]]) sm = 2*i+1;
        if (2*i+2 < size && nfreq[slots[2*i+2]] < nfreq[slots[sm]]) sm = 2*i+2;
        if (sm == i) return;
        t = slots[sm];
        slots[sm] = slots[i];
        slots[i] = t;
        i = sm;
      end
    endfunction

    function void push(int id);
      int i;
      if (hsize >= NSYM) return;
      slots[hsize] = id;
      hsize++;
      i = hsize - 1;
      while (i > 0) begin
        i = (i - 1) / 2;
        sift_down(hsize, i);
      end
    endfunction

    function int pop();
      int top;
      top = slots[0];
      slots[0] = slots[hsize-1];
      hsize--;
      sift_down(hsize, 0);
      return top;
    endfunction

    function void build_table();
      int n;
      int nxt;
      int l;
      int r;
      int done;
      code_entry_t e;
      n = 0;
      hsize = 0;
      builds++;
      for (int s = 0; s < NSYM; s++) begin
        if (counts[s] != 0) begin
          nfreq[n] = counts[s];
          kid_l[n] = NOKID;
          kid_r[n] = NOKID;
          nsym[n] = s;
          push(n);
          n++;
        end
      end
      if (n == 0) begin
        e = '0;
        e.none_present = 1'b1;
        e.last_code = 1'b1;
        pending.push_back(e);
        return;
      end
      nxt = n;
      while (hsize > 1 && nxt < NNODE) begin
        l = pop();
        r = pop();
        nfreq[nxt] = nfreq[l] + nfreq[r];
        kid_l[nxt] = l;
        kid_r[nxt] = r;
        push(nxt);
        nxt++;
      end
      ncode[nxt-1] = '0;
      nlen[nxt-1] = 0;
      for (int id = nxt - 1; id >= n; id--) begin
        l = kid_l[id];
        r = kid_r[id];
        ncode[l] = ncode[id] << 1;
        nlen[l] = nlen[id] + 1;
        ncode[r] = (ncode[id] << 1) | CODE_W'(1);
        nlen[r] = nlen[id] + 1;
      end
      done = 0;
      for (int id = 0; id < n; id++) begin
        done++;
        e.out_symbol = SYM_W'(nsym[id]);
        e.code_bits = ncode[id];
        e.code_length = LEN_W'(nlen[id]);
        e.none_present = 1'b0;
        e.last_code = (done == n);
        pending.push_back(e);
      end
    endfunction

    function void note_count(logic [SYM_W-1:0] sym, logic [FREQ_IN_W-1:0] freq,
                             logic last);
      if (sym < NSYM) counts[sym] = freq;
      if (last) begin
        build_table();
        clear_counts();
      end
    endfunction

    function void check_code(code_entry_t got);
      code_entry_t exp;
      codes_seen++;
      if (pending.size() == 0) begin
        $error("unexpected result transfer, symbol %0d", got.out_symbol);
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.out_symbol !== exp.out_symbol) begin
        $error("out_symbol: expected %0d, got %0d", exp.out_symbol, got.out_symbol);
        errors++;
      end
      if (got.code_bits !== exp.code_bits) begin
        $error("code_bits: expected %h, got %h", exp.code_bits, got.code_bits);
        errors++;
      end
      if (got.code_length !== exp.code_length) begin
        $error("code_length: expected %0d, got %0d", exp.code_length,
               got.code_length);
        errors++;
      end
      if (got.none_present !== exp.none_present) begin
        $error("none_present: expected %0d, got %0d", exp.none_present,
               got.none_present);
        errors++;
      end
      if (got.last_code !== exp.last_code) begin
        $error("last_code: expected %0d, got %0d", exp.last_code, got.last_code);
        errors++;
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;
  hcb_in_if  cnt_if ();
  hcb_out_if code_if ();

  huffman_code_table_builder dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (cnt_if.sink),
    .out_o  (code_if.source)
  );

  code_table_scoreboard sb;
  int hold_cycles = 0;
  int hold_seen = 0;
  int hold_req;
  int sent;
  bit quiet_sink;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  task automatic send_count(int sym, logic [FREQ_IN_W-1:0] freq, bit last,
                            bit gaps);
    int g;
    g = gaps ? pick_gap() : 0;
    if (g > 0) begin
      cnt_if.valid <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    cnt_if.valid <= 1'b1;
    cnt_if.symbol <= sym[SYM_W-1:0];
    cnt_if.frequency <= freq;
    cnt_if.last <= last;
    do @(posedge clk_i); while (!cnt_if.ready);
    sb.note_count(sym[SYM_W-1:0], freq, last);
    sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    cnt_if.valid <= 1'b0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(negedge clk_i);
  endtask

  function automatic logic [FREQ_IN_W-1:0] rand_freq();
    int p;
    p = $urandom_range(0, 9);
    if (p < 2) return '0;
    if (p < 5) return FREQ_IN_W'($urandom_range(1, 20));
    if (p < 7) return FREQ_IN_W'($urandom);
    return FREQ_IN_W'(24'hFF_FFFF - $urandom_range(0, 3));
  endfunction

  task automatic send_random_set(int kind);
    int cnt;
    int sym;
    cnt = (kind == 0) ? $urandom_range(1, 12) : $urandom_range(1, 45);
    for (int k = 0; k < cnt; k++) begin
      sym = ($urandom_range(0, 19) == 0) ? $urandom_range(NSYM, 63)
                                          : $urandom_range(0, NSYM - 1);
      send_count(sym, rand_freq(), k == cnt - 1, 1);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && code_if.valid && code_if.ready) begin
      sb.check_code({code_if.out_symbol, code_if.code_bits, code_if.code_length,
                     code_if.none_present, code_if.last_code});
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      code_if.ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cycles <= 4000;
      code_if.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      code_if.ready <= 1'b0;
    end else if (quiet_sink) begin
      code_if.ready <= 1'b1;
    end else if (code_if.ready) begin
      if ($urandom_range(0, 3) == 0) begin
        code_if.ready <= 1'b0;
        hold_cycles <= pick_gap();
      end
    end else begin
      code_if.ready <= 1'b1;
    end
  end

  initial begin
    sb = new();
    sb.clear_counts();
    sb.hsize = 0;
    sb.errors = 0;
    sb.builds = 0;
    sb.codes_seen = 0;
    hold_req = 0;
    quiet_sink = 1'b0;
    sent = 0;
    rst_ni = 1'b0;
    cnt_if.valid = 1'b0;
    cnt_if.symbol = '0;
    cnt_if.frequency = '0;
    cnt_if.last = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // Empty alphabet, then a lone symbol at each end of the alphabet.
    send_count(0, 0, 1, 0);
    send_count(NSYM - 1, 24'hFF_FFFF, 1, 0);
    send_count(0, 1, 1, 0);
    // Out-of-range index is ignored, repeated index overwrites.
    send_count(63, 24'h55_5555, 0, 0);
    send_count(NSYM, 5, 0, 0);
    send_count(3, 24'hAA_AAAA, 0, 0);
    send_count(3, 7, 0, 0);
    send_count(5, 7, 0, 0);
    send_count(63, 9, 1, 0);
    // Full alphabet with equal counts to exercise the tie rules.
    quiet_sink = 1'b1;
    for (int s = 0; s < NSYM; s++) send_count(s, 1, s == NSYM - 1, 0);
    // Deep skewed tree: power-of-two counts give codes up to 24 bits long.
    for (int s = 0; s < 25; s++) send_count(s, 24'd1 << (s > 23 ? 23 : s), s == 24, 0);
    quiet_sink = 1'b0;
    wait_drained();

    // Hold the receiver off while the sender keeps offering counts.
    hold_req++;
    send_random_set(0);
    send_random_set(0);
    wait_drained();

    while (sent < 280) begin
      send_random_set($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) wait_drained();
    end

    wait_drained();
    repeat (50) @(negedge clk_i);
    $display("Covered %0d count transfers, %0d table builds, %0d code results.",
             sent, sb.builds, sb.codes_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
